// ===== sv/tcsp_pkg.sv =====
// Package for the tag code-space parser: field widths, character codes,
// parse phases, status codes and character class helpers.
// Depends on nothing; the channel interfaces and the parser use it.
package tcsp_pkg;

    // Field widths of one input item and one result item.
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FREQ_W   = 10;
    localparam int CHAN_W   = 14;

    // Defaults for the digit limits of the two number fields.
    localparam int DEFAULT_MAX_FREQ_DIGITS    = 3;
    localparam int DEFAULT_MAX_CHANNEL_DIGITS = 4;

    // Character codes.
    localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_DASH = 8'h2D;

    // Status codes of a result.
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LETTER = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREQ    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_DASH    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_CHAN    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EXTRA      = 3'd5;

    // Parse phase, one-hot.
    typedef enum logic [2:0] {
        PH_LETTER = 3'b001,
        PH_FREQ   = 3'b010,
        PH_CHAN   = 3'b100
    } phase_t;

    // True for 'A'..'Z' and 'a'..'z'.
    function automatic logic is_letter(input logic [BYTE_W-1:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    // True for '0'..'9'.
    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

endpackage

// ===== sv/tcsp_channels.sv =====
// Valid/ready channel interfaces of the tag code-space parser: the character
// stream going in and the parse results coming out.
// Depends on tcsp_pkg for the field widths.
interface tcsp_text_if;
    logic                         valid;
    logic                         ready;
    logic [tcsp_pkg::BYTE_W-1:0]  text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface tcsp_result_if;
    logic                           valid;
    logic                           ready;
    logic [tcsp_pkg::STATUS_W-1:0]  status_code;
    logic [tcsp_pkg::BYTE_W-1:0]    tag_letter;
    logic [tcsp_pkg::FREQ_W-1:0]    frequency_code;
    logic [tcsp_pkg::CHAN_W-1:0]    channel_code;

    modport source (output valid, output status_code, output tag_letter,
                    output frequency_code, output channel_code, input ready);
    modport sink   (input valid, input status_code, input tag_letter,
                    input frequency_code, input channel_code, output ready);
endinterface

// ===== sv/tcsp_digit_acc.sv =====
// Decimal digit accumulator: value times ten plus one digit, saturating at
// the all-ones value of its width. Purely combinational.
// Depends on nothing outside this file.
module tcsp_digit_acc #(
    parameter int W = 10
) (
    input  logic [W-1:0] acc,
    input  logic [3:0]   digit,
    output logic [W-1:0] sum
);

    localparam int WIDE_W = W + 4;

    logic [WIDE_W-1:0] acc_wide;
    logic [WIDE_W-1:0] times_ten;
    logic [WIDE_W-1:0] raw_sum;

    // Times ten as a sum of two shifts, then add the digit.
    assign acc_wide  = {4'b0, acc};
    assign times_ten = (acc_wide << 3) + (acc_wide << 1);
    assign raw_sum   = times_ten + {{(WIDE_W-4){1'b0}}, digit};

    // Clamp to the largest value the field can hold.
    assign sum = (raw_sum[WIDE_W-1:W] != '0) ? {W{1'b1}} : raw_sum[W-1:0];

endmodule

// ===== sv/tag_code_space_parser.sv =====
// Tag code-space parser: one character per transfer, one result per string.
// Throughput: one character per cycle; the input stalls only while a result
// is held in the output register and the sink does not take it.
// The result of a string is valid in the cycle after its zero byte is taken.
// Reset (rst_n, asynchronous): parser returns to the letter phase with no
// error and cleared accumulators; no result is pending.
module tag_code_space_parser #(
    parameter int MAX_FREQ_DIGITS    = tcsp_pkg::DEFAULT_MAX_FREQ_DIGITS,
    parameter int MAX_CHANNEL_DIGITS = tcsp_pkg::DEFAULT_MAX_CHANNEL_DIGITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    tcsp_text_if.sink            text,
    tcsp_result_if.source        result
);

    localparam int FCNT_W = $clog2(MAX_FREQ_DIGITS + 1);
    localparam int CCNT_W = $clog2(MAX_CHANNEL_DIGITS + 1);
    localparam logic [FCNT_W-1:0] FCNT_MAX = FCNT_W'(MAX_FREQ_DIGITS);
    localparam logic [CCNT_W-1:0] CCNT_MAX = CCNT_W'(MAX_CHANNEL_DIGITS);

    // Parser state.
    tcsp_pkg::phase_t                phase_reg, phase_next;
    logic [tcsp_pkg::STATUS_W-1:0]   err_reg, err_next;
    logic [tcsp_pkg::BYTE_W-1:0]     letter_reg, letter_next;
    logic [tcsp_pkg::FREQ_W-1:0]     freq_reg, freq_next;
    logic [FCNT_W-1:0]               fcnt_reg, fcnt_next;
    logic [tcsp_pkg::CHAN_W-1:0]     chan_reg, chan_next;
    logic [CCNT_W-1:0]               ccnt_reg, ccnt_next;

    // Result register.
    logic                            res_valid_reg, res_valid_next;
    logic [tcsp_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [tcsp_pkg::BYTE_W-1:0]     res_letter_reg, res_letter_next;
    logic [tcsp_pkg::FREQ_W-1:0]     res_freq_reg, res_freq_next;
    logic [tcsp_pkg::CHAN_W-1:0]     res_chan_reg, res_chan_next;

    logic                            accept;
    logic                            is_end;
    logic                            is_dig;
    logic [tcsp_pkg::STATUS_W-1:0]   end_status;
    logic [tcsp_pkg::FREQ_W-1:0]     freq_acc;
    logic [tcsp_pkg::CHAN_W-1:0]     chan_acc;

    // Input is taken whenever the result register is free or draining.
    assign text.ready = !res_valid_reg || result.ready;
    assign accept     = text.valid && text.ready;
    assign is_end     = (text.text_byte == tcsp_pkg::CHAR_NUL);
    assign is_dig     = tcsp_pkg::is_digit(text.text_byte);

    // Multiply-by-ten accumulators for the two number fields.
    tcsp_digit_acc #(
        .W (tcsp_pkg::FREQ_W)
    ) u_freq_acc (
        .acc   (freq_reg),
        .digit (text.text_byte[3:0]),
        .sum   (freq_acc)
    );

    tcsp_digit_acc #(
        .W (tcsp_pkg::CHAN_W)
    ) u_chan_acc (
        .acc   (chan_reg),
        .digit (text.text_byte[3:0]),
        .sum   (chan_acc)
    );

    // Status reported at the terminator: the first error, what is missing, or OK.
    always_comb
    begin
        end_status = err_reg;
        if (err_reg == tcsp_pkg::ST_OK)
        begin
            unique case (phase_reg)
                tcsp_pkg::PH_LETTER:
                begin
                    end_status = tcsp_pkg::ST_BAD_LETTER;
                end
                tcsp_pkg::PH_FREQ:
                begin
                    end_status = (fcnt_reg == '0) ? tcsp_pkg::ST_NO_FREQ
                                                  : tcsp_pkg::ST_NO_DASH;
                end
                tcsp_pkg::PH_CHAN:
                begin
                    end_status = (ccnt_reg == '0) ? tcsp_pkg::ST_NO_CHAN
                                                  : tcsp_pkg::ST_OK;
                end
                default:
                begin
                    end_status = tcsp_pkg::ST_BAD_LETTER;
                end
            endcase
        end
    end

    // Next parser state for one accepted character.
    always_comb
    begin
        phase_next  = phase_reg;
        err_next    = err_reg;
        letter_next = letter_reg;
        freq_next   = freq_reg;
        fcnt_next   = fcnt_reg;
        chan_next   = chan_reg;
        ccnt_next   = ccnt_reg;
        if (accept)
        begin
            if (is_end)
            begin
                phase_next  = tcsp_pkg::PH_LETTER;
                err_next    = tcsp_pkg::ST_OK;
                letter_next = '0;
                freq_next   = '0;
                fcnt_next   = '0;
                chan_next   = '0;
                ccnt_next   = '0;
            end
            else if (err_reg == tcsp_pkg::ST_OK)
            begin
                unique case (phase_reg)
                    tcsp_pkg::PH_LETTER:
                    begin
                        if (tcsp_pkg::is_letter(text.text_byte))
                        begin
                            letter_next = text.text_byte;
                            phase_next  = tcsp_pkg::PH_FREQ;
                        end
                        else
                        begin
                            err_next = tcsp_pkg::ST_BAD_LETTER;
                        end
                    end
                    tcsp_pkg::PH_FREQ:
                    begin
                        if (is_dig && (fcnt_reg < FCNT_MAX))
                        begin
                            freq_next = freq_acc;
                            fcnt_next = fcnt_reg + 1'b1;
                        end
                        else if (fcnt_reg == '0)
                        begin
                            err_next = tcsp_pkg::ST_NO_FREQ;
                        end
                        else if (text.text_byte == tcsp_pkg::CHAR_DASH)
                        begin
                            phase_next = tcsp_pkg::PH_CHAN;
                        end
                        else
                        begin
                            err_next = tcsp_pkg::ST_NO_DASH;
                        end
                    end
                    tcsp_pkg::PH_CHAN:
                    begin
                        if (is_dig && (ccnt_reg < CCNT_MAX))
                        begin
                            chan_next = chan_acc;
                            ccnt_next = ccnt_reg + 1'b1;
                        end
                        else if (ccnt_reg == '0)
                        begin
                            err_next = tcsp_pkg::ST_NO_CHAN;
                        end
                        else
                        begin
                            err_next = tcsp_pkg::ST_EXTRA;
                        end
                    end
                    default:
                    begin
                        phase_next = tcsp_pkg::PH_LETTER;
                    end
                endcase
            end
        end
    end

    // Result register: loaded by a terminator, cleared when taken.
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_letter_next = res_letter_reg;
        res_freq_next   = res_freq_reg;
        res_chan_next   = res_chan_reg;
        if (accept && is_end)
        begin
            res_valid_next  = 1'b1;
            res_status_next = end_status;
            if (end_status == tcsp_pkg::ST_OK)
            begin
                res_letter_next = letter_reg;
                res_freq_next   = freq_reg;
                res_chan_next   = chan_reg;
            end
            else
            begin
                res_letter_next = '0;
                res_freq_next   = '0;
                res_chan_next   = '0;
            end
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Control and parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tcsp_pkg::PH_LETTER;
            err_reg       <= tcsp_pkg::ST_OK;
            letter_reg    <= '0;
            freq_reg      <= '0;
            fcnt_reg      <= '0;
            chan_reg      <= '0;
            ccnt_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            err_reg       <= err_next;
            letter_reg    <= letter_next;
            freq_reg      <= freq_next;
            fcnt_reg      <= fcnt_next;
            chan_reg      <= chan_next;
            ccnt_reg      <= ccnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_letter_reg <= res_letter_next;
        res_freq_reg   <= res_freq_next;
        res_chan_reg   <= res_chan_next;
    end

    assign result.valid          = res_valid_reg;
    assign result.status_code    = res_status_reg;
    assign result.tag_letter     = res_letter_reg;
    assign result.frequency_code = res_freq_reg;
    assign result.channel_code   = res_chan_reg;

    // A new result appears only after a terminator was transferred.
    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(accept && is_end))
        else $error("result appeared without a terminator transfer");

    // A terminator leaves the parser in its start state.
    a_restart_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_end) |=> (phase_reg == tcsp_pkg::PH_LETTER)
                               && (err_reg == tcsp_pkg::ST_OK)
                               && (fcnt_reg == '0) && (ccnt_reg == '0))
        else $error("parser did not restart after a terminator");

    // An error result carries zero fields.
    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_status_reg != tcsp_pkg::ST_OK))
        |-> (res_letter_reg == '0) && (res_freq_reg == '0) && (res_chan_reg == '0))
        else $error("error result with nonzero fields");

    // Digit counts never pass their limits.
    a_count_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (fcnt_reg <= FCNT_MAX) && (ccnt_reg <= CCNT_MAX))
        else $error("digit count beyond its limit");

    // Channel digits are only counted once the dash has been seen.
    a_chan_after_dash: assert property (@(posedge clk) disable iff (!rst_n)
        (ccnt_reg != '0) |-> (phase_reg == tcsp_pkg::PH_CHAN) && (fcnt_reg != '0))
        else $error("channel digits counted outside the channel phase");

endmodule
